// ----- hdl/tgkc_pkg.sv -----
// types, codes and the chord table for the touch grid to key chord translator
// no dependencies; imported by touch_grid_to_key_chords
package tgkc_pkg;

   // input transaction kinds, carried on req_tuser
   localparam logic [1:0] MODE_TOUCH   = 2'd0;
   localparam logic [1:0] MODE_SUSPEND = 2'd1;
   localparam logic [1:0] MODE_RESUME  = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_PANEL_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_PANEL_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_KEYBOARD_TOP  = 2'd2;
   localparam logic [1:0] CSR_POLL_INTERVAL = 2'd3;

   // register reset values
   localparam logic [11:0] PANEL_WIDTH_RST   = 12'd320;
   localparam logic [11:0] PANEL_HEIGHT_RST  = 12'd240;
   localparam logic [11:0] KEYBOARD_TOP_RST  = 12'd240;
   localparam logic [15:0] POLL_INTERVAL_RST = 16'd20;

   // fn key position in the matrix
   localparam logic [1:0] FN_ROW = 2'd2;
   localparam logic [3:0] FN_COL = 4'd0;

   // held cell code for no chord held
   localparam logic [3:0] NO_CELL = 4'd15;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_POLL,
      S_BAND,
      S_X1,
      S_X2,
      S_Y1,
      S_Y2,
      S_MAP,
      S_EMIT
   } tgkc_state_type;

   typedef struct packed {
      logic       used;
      logic [1:0] row;
      logic [3:0] col;
      logic       fn;
   } chord_type;

   // 3x3 grid cells, row-major; anything past the grid maps to nothing
   function automatic chord_type chord_of(input logic [3:0] cell_idx);
      chord_type c;
      case (cell_idx)
         4'd0:    c = '{used: 1'b1, row: 2'd0, col: 4'd0,  fn: 1'b1};
         4'd1:    c = '{used: 1'b1, row: 2'd2, col: 4'd11, fn: 1'b1};
         4'd3:    c = '{used: 1'b1, row: 2'd3, col: 4'd10, fn: 1'b1};
         4'd4:    c = '{used: 1'b1, row: 2'd2, col: 4'd13, fn: 1'b0};
         4'd5:    c = '{used: 1'b1, row: 2'd3, col: 4'd12, fn: 1'b1};
         4'd7:    c = '{used: 1'b1, row: 2'd3, col: 4'd11, fn: 1'b1};
         4'd8:    c = '{used: 1'b1, row: 2'd3, col: 4'd13, fn: 1'b0};
         default: c = '{used: 1'b0, row: 2'd0, col: 4'd0,  fn: 1'b0};
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/touch_grid_to_key_chords.sv -----
// touch grid to key chord translator, top level
// depends on tgkc_pkg for state codes, register indexes and the chord table
//
// Takes one transaction at a time: a touch sample, a suspend or a resume. The input is
// held off (req_tready low) while a sample is being worked on. A small sequencer runs
// every test through one shared 32-bit magnitude comparator: poll time, keyboard band,
// then two threshold tests per axis (3v >= size and 3v >= 2*size) that give the
// clamped grid index without a divider. Resume, unused modes, samples ignored while
// suspended and a suspend with no chord to release end at the dispatch step; samples
// dropped at the poll test, with no change of touch state or lifting with no chord held
// end at the poll step; a new touch in the keyboard band or on a zero panel size ends
// at the band step; a corner with no chord frees the input at the map step. Key events
// then pass one at a time through the output register, and up to two are sent per
// transaction (fn before key on press, key before fn on release), with rsp_tlast
// marking the final one. The output register can hold a finished event while the next
// transaction is accepted. Registers must be written through the csr port only while
// the block is idle; the block itself does not enforce this. csr_ready is always high.
module touch_grid_to_key_chords (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // now_ms[31:0], touch_down[32], touch_x[44:33],
                                   // touch_y[56:45], zero fill [63:57]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // key_down[0], key_row[2:1], key_col[6:3], zero [7]
   output logic        rsp_tlast,  // last_event
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tgkc_pkg::*;

   // configuration registers
   logic [11:0] panel_width_ff;
   logic [11:0] panel_height_ff;
   logic [11:0] keyboard_top_ff;
   logic [15:0] poll_interval_ff;

   // sequencer and architectural state
   tgkc_state_type state_ff, state_in;
   logic        was_touching_ff, was_touching_in;
   logic        is_suspended_ff, is_suspended_in;
   logic [3:0]  held_cell_ff, held_cell_in;
   logic [31:0] next_poll_ff, next_poll_in;

   // captured transaction
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] now_ff, now_in;
   logic        down_ff, down_in;
   logic [11:0] x_ff, x_in;
   logic [11:0] y_ff, y_in;

   // grid indexes under construction
   logic [1:0]  cx_ff, cx_in;
   logic [1:0]  cy_ff, cy_in;

   // chord being sent
   logic [3:0]  ev_cell_ff, ev_cell_in;
   logic        ev_down_ff, ev_down_in;
   logic        ev_idx_ff, ev_idx_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // shared comparator
   logic [31:0] cmp_a;
   logic [31:0] cmp_b;
   logic        cmp_ge;
   logic        cmp_hit;

   logic [11:0] tri_src;
   logic [12:0] tri_val;
   logic        out_free;
   logic [3:0]  grid_cell;
   chord_type   held_chord;
   chord_type   grid_chord;
   chord_type   ev_chord;
   logic        ev_is_fn;
   logic        ev_last;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // output register may take a new event when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   // 3v for the axis under test; only the non-negative range reaches the comparator
   assign tri_src = (state_ff == S_X1 || state_ff == S_X2) ? x_ff : y_ff;
   assign tri_val = 13'(tri_src[10:0]) + 13'({tri_src[10:0], 1'b0});

   // operand select for the shared comparator
   always_comb begin
      cmp_a = '0;
      cmp_b = '0;
      case (state_ff)
         S_POLL: begin
            cmp_a = now_ff;
            cmp_b = next_poll_ff;
         end
         S_BAND: begin
            cmp_a = 32'(y_ff[10:0]);
            cmp_b = 32'(keyboard_top_ff);
         end
         S_X1: begin
            cmp_a = 32'(tri_val);
            cmp_b = 32'(panel_width_ff);
         end
         S_X2: begin
            cmp_a = 32'(tri_val);
            cmp_b = 32'({panel_width_ff, 1'b0});
         end
         S_Y1: begin
            cmp_a = 32'(tri_val);
            cmp_b = 32'(panel_height_ff);
         end
         S_Y2: begin
            cmp_a = 32'(tri_val);
            cmp_b = 32'({panel_height_ff, 1'b0});
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   assign cmp_ge = (cmp_a >= cmp_b);

   // a negative coordinate never reaches the band and always lands in column or row 0
   always_comb begin
      case (state_ff)
         S_POLL:  cmp_hit = cmp_ge;
         S_BAND:  cmp_hit = cmp_ge && !y_ff[11];
         default: cmp_hit = cmp_ge && !tri_src[11];
      endcase
   end

   assign grid_cell  = 4'({cy_ff, 1'b0}) + 4'(cy_ff) + 4'(cx_ff);
   assign grid_chord = chord_of(grid_cell);
   assign held_chord = chord_of(held_cell_ff);
   assign ev_chord   = chord_of(ev_cell_ff);

   // press: fn then key; release: key then fn
   assign ev_is_fn = ev_chord.fn && (ev_idx_ff ? !ev_down_ff : ev_down_ff);
   assign ev_last  = !ev_chord.fn || ev_idx_ff;

   // sequencer: next state and next values
   always_comb begin
      state_in        = state_ff;
      was_touching_in = was_touching_ff;
      is_suspended_in = is_suspended_ff;
      held_cell_in    = held_cell_ff;
      next_poll_in    = next_poll_ff;
      mode_in         = mode_ff;
      now_in          = now_ff;
      down_in         = down_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      ev_cell_in      = ev_cell_ff;
      ev_down_in      = ev_down_ff;
      ev_idx_in       = ev_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               now_in   = req_tdata[31:0];
               down_in  = req_tdata[32];
               x_in     = req_tdata[44:33];
               y_in     = req_tdata[56:45];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            if (mode_ff == MODE_SUSPEND) begin
               is_suspended_in = 1'b1;
               if (was_touching_ff) begin
                  was_touching_in = 1'b0;
                  held_cell_in    = NO_CELL;
                  ev_cell_in      = held_cell_ff;
                  ev_down_in      = 1'b0;
                  ev_idx_in       = 1'b0;
                  if (held_chord.used) begin
                     state_in = S_EMIT;
                  end
               end
            end else if (mode_ff == MODE_RESUME) begin
               is_suspended_in = 1'b0;
            end else if (mode_ff == MODE_TOUCH && !is_suspended_ff) begin
               state_in = S_POLL;
            end
         end
         S_POLL: begin
            state_in = S_IDLE;
            if (cmp_hit) begin
               next_poll_in = now_ff + 32'(poll_interval_ff);
               if (down_ff != was_touching_ff) begin
                  was_touching_in = down_ff;
                  if (!down_ff) begin
                     // lift: release whatever chord is held
                     held_cell_in = NO_CELL;
                     ev_cell_in   = held_cell_ff;
                     ev_down_in   = 1'b0;
                     ev_idx_in    = 1'b0;
                     if (held_chord.used) begin
                        state_in = S_EMIT;
                     end
                  end else begin
                     state_in = S_BAND;
                  end
               end
            end
         end
         S_BAND: begin
            state_in = S_IDLE;
            if (cmp_hit) begin
               // new touch inside the keyboard band is dropped
               was_touching_in = 1'b0;
            end else if (panel_width_ff != '0 && panel_height_ff != '0) begin
               cx_in    = '0;
               cy_in    = '0;
               state_in = S_X1;
            end
         end
         S_X1: begin
            if (cmp_hit) begin
               cx_in = 2'd1;
            end
            state_in = S_X2;
         end
         S_X2: begin
            if (cmp_hit) begin
               cx_in = 2'd2;
            end
            state_in = S_Y1;
         end
         S_Y1: begin
            if (cmp_hit) begin
               cy_in = 2'd1;
            end
            state_in = S_Y2;
         end
         S_Y2: begin
            if (cmp_hit) begin
               cy_in = 2'd2;
            end
            state_in = S_MAP;
         end
         S_MAP: begin
            ev_cell_in = grid_cell;
            ev_down_in = 1'b1;
            ev_idx_in  = 1'b0;
            if (grid_chord.used) begin
               held_cell_in = grid_cell;
               state_in     = S_EMIT;
            end else begin
               // corner with no chord
               held_cell_in = NO_CELL;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = ev_last;
               if (ev_is_fn) begin
                  rsp_data_in = {1'b0, FN_COL, FN_ROW, ev_down_ff};
               end else begin
                  rsp_data_in = {1'b0, ev_chord.col, ev_chord.row, ev_down_ff};
               end
               if (ev_last) begin
                  state_in = S_IDLE;
               end else begin
                  ev_idx_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         was_touching_ff  <= 1'b0;
         is_suspended_ff  <= 1'b0;
         held_cell_ff     <= NO_CELL;
         next_poll_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         panel_width_ff   <= PANEL_WIDTH_RST;
         panel_height_ff  <= PANEL_HEIGHT_RST;
         keyboard_top_ff  <= KEYBOARD_TOP_RST;
         poll_interval_ff <= POLL_INTERVAL_RST;
      end else begin
         state_ff        <= state_in;
         was_touching_ff <= was_touching_in;
         is_suspended_ff <= is_suspended_in;
         held_cell_ff    <= held_cell_in;
         next_poll_ff    <= next_poll_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_PANEL_WIDTH:   panel_width_ff   <= csr_data[11:0];
               CSR_PANEL_HEIGHT:  panel_height_ff  <= csr_data[11:0];
               CSR_KEYBOARD_TOP:  keyboard_top_ff  <= csr_data[11:0];
               CSR_POLL_INTERVAL: poll_interval_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      down_ff     <= down_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      ev_cell_ff  <= ev_cell_in;
      ev_down_ff  <= ev_down_in;
      ev_idx_ff   <= ev_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // no chord can be held without a touch in progress
   assert property (@(posedge clock) disable iff (reset)
      !was_touching_ff |-> held_cell_ff == NO_CELL)
      else $error("chord held with no touch in progress");

   // suspend drops the touch and samples are ignored until resume
   assert property (@(posedge clock) disable iff (reset)
      is_suspended_ff |-> !was_touching_ff)
      else $error("touch in progress while suspended");

   // a held cell always names a real chord
   assert property (@(posedge clock) disable iff (reset)
      held_cell_ff != NO_CELL |-> held_chord.used)
      else $error("held cell maps to no chord");

   // every transaction takes the sequencer out of idle, so req_tready drops once it is accepted
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while sequencer busy");

   // a second event only follows a chord that carries fn
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && ev_idx_ff |-> ev_chord.fn)
      else $error("second event for a chord without fn");

endmodule
